/* rtl/spf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, register indices and colour constants for the paletted
// sprite pixel fetch.
// ----------------------------------------------------------------------------
package spf_pkg;

	// Item kinds carried by the command channel
	typedef enum logic [1:0] {
		KIND_SHEET   = 2'd0,
		KIND_PALETTE = 2'd1,
		KIND_RENDER  = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	// Configuration register indices
	typedef enum logic [2:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Y   = 3'd1,
		REG_SPR_WIDTH  = 3'd2,
		REG_SPR_HEIGHT = 3'd3,
		REG_FLIP_MODE  = 3'd4,
		REG_PAL_OFFSET = 3'd5,
		REG_BRIGHTNESS = 3'd6,
		REG_COLOR_SWAP = 3'd7
	} reg_idx_t;

	// 1-5-5-5 colour fields
	localparam logic [15:0] ALPHA_MASK = 16'h8000;
	localparam logic [15:0] RED_MASK   = 16'h7C00;
	localparam logic [15:0] GREEN_MASK = 16'h03E0;
	localparam logic [15:0] BLUE_MASK  = 16'h001F;
	localparam logic [7:0]  CHAN_MAX   = 8'hFF;

	// Item fields that ride along the pipeline
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  pos_x;
		logic [7:0]  pos_y;
		logic [7:0]  pal_addr;
		logic [7:0]  sheet_value;
		logic [15:0] color_value;
		logic        wr_ok;
	} item_t;

	// Channel times brightness, saturated at full scale
	function automatic logic [7:0] scale_chan(logic [4:0] c, logic [3:0] k);
		logic [8:0] p;
		p = 9'(c) * 9'(k);
		return (p > 9'(CHAN_MAX)) ? CHAN_MAX : p[7:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/spf_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_mod
// Two-stage remainder by a constant: reciprocal multiply, then one
// back-multiply, subtract and single correction step.
// ----------------------------------------------------------------------------
module spf_mod #(
	parameter int DIVISOR = 256,
	parameter int IN_W    = 11
) (
	input  wire logic                       clk,
	input  wire logic [IN_W-1:0]            value,
	output logic      [$clog2(DIVISOR)-1:0] rem
);

	localparam int SHIFT = 2 * IN_W;
	localparam int PW    = IN_W + SHIFT + 1;
	localparam logic [SHIFT:0]   RECIP = (SHIFT + 1)'((64'd1 << SHIFT) / DIVISOR);
	localparam logic [IN_W-1:0]  DIV_C = IN_W'(DIVISOR);

	logic [IN_W-1:0]   v_s1;
	logic [PW-1:0]     prod_s1;
	logic [IN_W-1:0]   quot;
	logic [2*IN_W-1:0] back;
	logic [IN_W-1:0]   diff;
	logic [IN_W-1:0]   rem_s2;

	// stage 1: quotient estimate, low by at most one
	always_ff @(posedge clk) begin
		v_s1    <= value;
		prod_s1 <= PW'(value) * PW'(RECIP);
	end

	// stage 2: remainder with one correction
	always_comb begin
		quot = prod_s1[SHIFT +: IN_W];
		back = (2 * IN_W)'(quot) * (2 * IN_W)'(DIV_C);
		diff = v_s1 - back[IN_W-1:0];
	end

	always_ff @(posedge clk) begin
		rem_s2 <= (diff >= DIV_C) ? (diff - DIV_C) : diff;
	end

	assign rem = rem_s2[$clog2(DIVISOR)-1:0];

endmodule
`default_nettype wire

/* rtl/sprite_palette_pixel_fetch.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_palette_pixel_fetch
// Indexed sprite sheet and 1-5-5-5 palette with ARGB pixel expansion.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken on each edge with start high and busy
//   low. busy stays low, so one item per clock is accepted. Kind 0 writes a
//   sheet pixel, kind 1 a palette entry; neither gives a result. Kind 2
//   renders one sprite pixel; kind 3 is dropped.
//   Results: done is high for one cycle with argb, out_x and out_y; the
//   receiver has no back-pressure. A taken render beat passes through
//   stages 1 to 8; its result is shown from the stage 9 output registers.
//   Throughput is one item per clock; both memories are accessed once per
//   item, each in its own pipeline stage, so writes and reads stay ordered.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high,
//   cfg_index selects the register. Write it only while the pipeline is
//   empty (nine idle cycles after the last item).
//   Reset: arst_n clears the pipeline valid bits and returns the configuration
//   registers to their reset values. Sheet and palette contents are undefined
//   until written.
// ----------------------------------------------------------------------------
module sprite_palette_pixel_fetch #(
	parameter int SHEET_WIDTH  = 256,
	parameter int SHEET_HEIGHT = 256,
	parameter int PALETTE_SIZE = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  pos_x,
	input  wire logic [7:0]  pos_y,
	input  wire logic [7:0]  pal_addr,
	input  wire logic [7:0]  sheet_value,
	input  wire logic [15:0] color_value,
	// result channel
	output logic             done,
	output logic [31:0]      argb,
	output logic [7:0]       out_x,
	output logic [7:0]       out_y,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);

	import spf_pkg::*;

	localparam int XW     = $clog2(SHEET_WIDTH);
	localparam int YW     = $clog2(SHEET_HEIGHT);
	localparam int AW     = $clog2(SHEET_WIDTH * SHEET_HEIGHT);
	localparam int DEPTH  = SHEET_WIDTH * SHEET_HEIGHT;
	localparam int PW     = $clog2(PALETTE_SIZE);
	localparam int CW     = 11;
	localparam int BIAS_X = SHEET_WIDTH * ((256 + SHEET_WIDTH - 1) / SHEET_WIDTH);
	localparam int BIAS_Y = SHEET_HEIGHT * ((256 + SHEET_HEIGHT - 1) / SHEET_HEIGHT);

	// configuration registers
	logic [7:0] origin_x_q;
	logic [7:0] origin_y_q;
	logic [8:0] spr_width_q;
	logic [8:0] spr_height_q;
	logic [1:0] flip_mode_q;
	logic [7:0] pal_offset_q;
	logic [3:0] brightness_q;
	logic       color_swap_q;

	// pipeline control and payload
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	item_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	item_t side_in;
	logic [11:0]   col_c, row_c;
	logic [CW-1:0] vx_s1, vy_s1;
	logic [XW-1:0] sx_s3;
	logic [YW-1:0] sy_s3;
	logic [AW-1:0] addr_s4;
	logic [7:0]    sidx_s5;
	logic [8:0]    pal_sum;
	logic [PW-1:0] pidx_s7;
	logic [PW-1:0] pal_waddr;
	logic [15:0]   c16_s8;
	logic          sheet_we, pal_we;
	logic          done_s9;
	logic [31:0]   argb_s9;
	logic [7:0]    out_x_s9, out_y_s9;
	logic [4:0]    ch_r, ch_g, ch_b;
	logic          ch_a;

	// memories
	logic [7:0]  sheet_mem [DEPTH];
	logic [15:0] pal_mem [PALETTE_SIZE];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			spr_width_q  <= 9'd16;
			spr_height_q <= 9'd16;
			flip_mode_q  <= '0;
			pal_offset_q <= '0;
			brightness_q <= 4'd8;
			color_swap_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ORIGIN_X:   origin_x_q   <= cfg_data[7:0];
				REG_ORIGIN_Y:   origin_y_q   <= cfg_data[7:0];
				REG_SPR_WIDTH:  spr_width_q  <= cfg_data;
				REG_SPR_HEIGHT: spr_height_q <= cfg_data;
				REG_FLIP_MODE:  flip_mode_q  <= cfg_data[1:0];
				REG_PAL_OFFSET: pal_offset_q <= cfg_data[7:0];
				REG_BRIGHTNESS: brightness_q <= cfg_data[3:0];
				REG_COLOR_SWAP: color_swap_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage 0: mirror and add origin, biased to stay non-negative (sheet writes keep their raw position)
	always_comb begin
		side_in.kind        = kind_t'(kind);
		side_in.pos_x       = pos_x;
		side_in.pos_y       = pos_y;
		side_in.pal_addr    = pal_addr;
		side_in.sheet_value = sheet_value;
		side_in.color_value = color_value;
		case (kind_t'(kind))
			KIND_SHEET:   side_in.wr_ok = (32'(pos_x) < 32'(SHEET_WIDTH))
				&& (32'(pos_y) < 32'(SHEET_HEIGHT));
			KIND_PALETTE: side_in.wr_ok = 32'(pal_addr) < 32'(PALETTE_SIZE);
			default:      side_in.wr_ok = 1'b0;
		endcase

		if (kind_t'(kind) == KIND_SHEET) begin
			col_c = 12'(pos_x);
			row_c = 12'(pos_y);
		end else begin
			if (flip_mode_q[0]) begin
				col_c = 12'(origin_x_q) + 12'(spr_width_q) - 12'd1 - 12'(pos_x)
					+ 12'(BIAS_X);
			end else begin
				col_c = 12'(origin_x_q) + 12'(pos_x) + 12'(BIAS_X);
			end
			if (flip_mode_q[1]) begin
				row_c = 12'(origin_y_q) + 12'(spr_height_q) - 12'd1 - 12'(pos_y)
					+ 12'(BIAS_Y);
			end else begin
				row_c = 12'(origin_y_q) + 12'(pos_y) + 12'(BIAS_Y);
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			done_s9 <= 1'b0;
		end else begin
			vld_s1  <= start && !busy && (kind_t'(kind) != KIND_NONE);
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			done_s9 <= vld_s8 && (side_s8.kind == KIND_RENDER);
		end
	end

	// payload shift
	always_ff @(posedge clk) begin
		side_s1 <= side_in;
		vx_s1   <= col_c[CW-1:0];
		vy_s1   <= row_c[CW-1:0];
		side_s2 <= side_s1;
		side_s3 <= side_s2;
		side_s4 <= side_s3;
		side_s5 <= side_s4;
		side_s6 <= side_s5;
		side_s7 <= side_s6;
		side_s8 <= side_s7;
	end

	// stages 2-3: wrap into the sheet
	spf_mod #(.DIVISOR(SHEET_WIDTH), .IN_W(CW)) u_mod_x (
		.clk   (clk),
		.value (vx_s1),
		.rem   (sx_s3)
	);

	spf_mod #(.DIVISOR(SHEET_HEIGHT), .IN_W(CW)) u_mod_y (
		.clk   (clk),
		.value (vy_s1),
		.rem   (sy_s3)
	);

	// stage 4: linear sheet address
	always_ff @(posedge clk) begin
		addr_s4 <= AW'(sy_s3) * AW'(SHEET_WIDTH) + AW'(sx_s3);
	end

	// stage 5: sheet access, writes and reads in program order
	assign sheet_we = vld_s4 && (side_s4.kind == KIND_SHEET) && side_s4.wr_ok;

	always_ff @(posedge clk) begin
		if (sheet_we) begin
			sheet_mem[addr_s4] <= side_s4.sheet_value;
		end
		sidx_s5 <= sheet_mem[addr_s4];
	end

	// stages 6-7: palette index with offset, wrapped
	assign pal_sum = 9'(sidx_s5) + 9'(pal_offset_q);

	spf_mod #(.DIVISOR(PALETTE_SIZE), .IN_W(9)) u_mod_pal (
		.clk   (clk),
		.value (pal_sum),
		.rem   (pidx_s7)
	);

	// stage 8: palette access
	assign pal_we    = vld_s7 && (side_s7.kind == KIND_PALETTE) && side_s7.wr_ok;
	assign pal_waddr = side_s7.pal_addr[PW-1:0];

	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[pal_waddr] <= side_s7.color_value;
		end
		c16_s8 <= pal_mem[pidx_s7];
	end

	// stage 9: colour expansion
	always_comb begin
		ch_a = (c16_s8 & ALPHA_MASK) != 16'd0;
		ch_g = 5'((c16_s8 & GREEN_MASK) >> 5);
		if (color_swap_q) begin
			ch_r = 5'(c16_s8 & BLUE_MASK);
			ch_b = 5'((c16_s8 & RED_MASK) >> 10);
		end else begin
			ch_r = 5'((c16_s8 & RED_MASK) >> 10);
			ch_b = 5'(c16_s8 & BLUE_MASK);
		end
	end

	always_ff @(posedge clk) begin
		argb_s9  <= {(ch_a ? CHAN_MAX : 8'd0), scale_chan(ch_r, brightness_q),
			scale_chan(ch_g, brightness_q), scale_chan(ch_b, brightness_q)};
		out_x_s9 <= side_s8.pos_x;
		out_y_s9 <= side_s8.pos_y;
	end

	assign done  = done_s9;
	assign argb  = argb_s9;
	assign out_x = out_x_s9;
	assign out_y = out_y_s9;

`ifndef SYNTHESIS
	// a result beat follows every render item leaving stage 8, and nothing else
	a_done_from_render: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(vld_s8 && (side_s8.kind == KIND_RENDER)))
		else $error("result strobe out of step with render items");

	// wrapped coordinates land inside the sheet
	a_sx_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (32'(sx_s3) < 32'(SHEET_WIDTH)))
		else $error("sheet column out of range");

	a_sy_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (32'(sy_s3) < 32'(SHEET_HEIGHT)))
		else $error("sheet row out of range");

	// palette index stays within the palette
	a_pidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 |-> (32'(pidx_s7) < 32'(PALETTE_SIZE)))
		else $error("palette index out of range");
`endif

endmodule
`default_nettype wire
